// ===== hw/rtl/gts_pkg.sv =====
// gts_pkg: shared types, widths and saturation helpers of the trajectory smoother
// used by the core, gts_front, gts_cmdq and gts_back; depends on nothing
package gts_pkg;

	localparam int PATH_W = 40;
	localparam int CNT_W  = 8;
	localparam int IDX_W  = 16;
	localparam int ACC_W  = 64;
	localparam int WGT_W  = 16;
	localparam int WSUM_W = 24;
	localparam int PROD_W = PATH_W + WGT_W + 1;

	typedef struct packed {
		logic signed [PATH_W-1:0] px;
		logic signed [PATH_W-1:0] py;
		logic signed [PATH_W-1:0] pa;
		logic                     eoc;
		logic [CNT_W-1:0]         pend;
		logic [CNT_W-1:0]         fill;
		logic [IDX_W-1:0]         fidx;
	} gts_cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_WALK,
		BK_DRAIN,
		BK_DIV,
		BK_WAIT,
		BK_OUT
	} bk_state_t;

	localparam logic signed [ACC_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;
	localparam logic signed [ACC_W-1:0] S24_MAX = 64'sh0000_0000_007F_FFFF;
	localparam logic signed [ACC_W-1:0] S24_MIN = 64'shFFFF_FFFF_FF80_0000;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
		return c[31:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = (v > S24_MAX) ? S24_MAX : ((v < S24_MIN) ? S24_MIN : v);
		return c[23:0];
	endfunction

endpackage

// ===== hw/rtl/gaussian_trajectory_smoother_core.sv =====
// gaussian_trajectory_smoother_core: top level of the gaussian trajectory smoother
// depends on gts_pkg, gts_front, gts_cmdq, gts_back (gts_ram, gts_div)
//
// channel  | handshake       | beat
// frames   | push / full     | dx, dy, da, end_of_clip
// results  | empty / pop     | frame_index, diff_x, diff_y, diff_angle, last_result
//
// a frame is registered into a two entry queue when accepted; the back end pops it when idle
// each correction walks 2*RADIUS+1 taps, drains the tap pipeline, starts the divide, waits on the
// bit serial divider and then loads the result register
// an end of clip frame runs up to RADIUS+1 corrections back to back
// reset is asynchronous and clears counters, path sums and all valid flags
// a stalled result holds the back end in place; the front keeps taking frames
// until the queue is full
module gaussian_trajectory_smoother_core #(
	parameter int RADIUS = 60
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [23:0] dx,
	input  logic signed [23:0] dy,
	input  logic signed [15:0] da,
	input  logic               end_of_clip,
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        frame_index,
	output logic signed [31:0] diff_x,
	output logic signed [31:0] diff_y,
	output logic signed [23:0] diff_angle,
	output logic               last_result
);
	import gts_pkg::*;

	gts_cmd_t f_cmd, q_cmd;
	logic     f_push, q_full, q_empty, q_pop;

	gts_front #(.RADIUS(RADIUS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.dx          (dx),
		.dy          (dy),
		.da          (da),
		.end_of_clip (end_of_clip),
		.cmd_push    (f_push),
		.cmd         (f_cmd),
		.cmd_full    (q_full)
	);

	gts_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  (f_cmd),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_cmd),
		.empty  (q_empty)
	);

	gts_back #(.RADIUS(RADIUS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (q_empty),
		.cmd         (q_cmd),
		.cmd_pop     (q_pop),
		.empty       (empty),
		.pop         (pop),
		.frame_index (frame_index),
		.diff_x      (diff_x),
		.diff_y      (diff_y),
		.diff_angle  (diff_angle),
		.last_result (last_result)
	);
endmodule

// ===== hw/rtl/gts_ram.sv =====
// gts_ram: generic single write port, single read port ram with registered read
// no dependencies
module gts_ram #(
	parameter int WIDTH = 120,
	parameter int DEPTH = 121
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/gts_div.sv =====
// gts_div: restoring divider, one quotient bit per cycle
// no package dependencies
module gts_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W:0]   trial, sub;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign sub   = trial - {1'b0, den_q};
	assign busy  = cnt_q != '0;
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy)
		else $error("divider started while busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> rem_q < den_q)
		else $error("divider remainder out of range");
endmodule

// ===== hw/rtl/gts_cmdq.sv =====
// gts_cmdq: two entry queue of classified frames between front and back
// depends on gts_pkg
module gts_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  gts_pkg::gts_cmd_t wdata,
	output logic              full,
	input  logic              rd,
	output gts_pkg::gts_cmd_t rdata,
	output logic              empty
);
	import gts_pkg::*;

	gts_cmd_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= !wp_q;
			end
			if (do_rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end
endmodule

// ===== hw/rtl/gts_front.sv =====
// gts_front: accepts frame beats, integrates the path and counts pending corrections
// depends on gts_pkg
module gts_front #(
	parameter int RADIUS = 60
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [23:0] dx,
	input  logic signed [23:0] dy,
	input  logic signed [15:0] da,
	input  logic               end_of_clip,
	output logic               cmd_push,
	output gts_pkg::gts_cmd_t  cmd,
	input  logic               cmd_full
);
	import gts_pkg::*;

	localparam int DEPTH = 2 * RADIUS + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] RAD_C   = CNT_W'(RADIUS);
	localparam logic [IDX_W-1:0] LIM     = IDX_W'(RADIUS + 1);

	logic signed [PATH_W-1:0] px_q, py_q, pa_q, px_n, py_n, pa_n;
	logic [IDX_W-1:0]         fin_q, fout_q, fin_n, diff, p1;
	logic [CNT_W-1:0]         fill_q, fill_n, pend;
	logic                     accept;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign cmd_push = accept;

	assign px_n   = px_q + PATH_W'(dx);
	assign py_n   = py_q + PATH_W'(dy);
	assign pa_n   = pa_q + PATH_W'(da);
	assign fill_n = (fill_q < DEPTH_C) ? fill_q + 1'b1 : fill_q;
	assign fin_n  = fin_q + 1'b1;
	assign diff   = fin_n - fout_q;
	assign p1     = (diff > LIM) ? LIM : diff;
	assign pend   = (p1 > IDX_W'(fill_n)) ? fill_n : p1[CNT_W-1:0];

	always_comb begin
		cmd.px   = px_n;
		cmd.py   = py_n;
		cmd.pa   = pa_n;
		cmd.eoc  = end_of_clip;
		cmd.pend = pend;
		cmd.fill = fill_n;
		cmd.fidx = fout_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q   <= '0;
			py_q   <= '0;
			pa_q   <= '0;
			fin_q  <= '0;
			fout_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (end_of_clip) begin
				px_q   <= '0;
				py_q   <= '0;
				pa_q   <= '0;
				fin_q  <= '0;
				fout_q <= '0;
				fill_q <= '0;
			end else begin
				px_q   <= px_n;
				py_q   <= py_n;
				pa_q   <= pa_n;
				fin_q  <= fin_n;
				fill_q <= fill_n;
				if (pend > RAD_C) begin
					fout_q <= fout_q + 1'b1;
				end
			end
		end
	end

	a_pend_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> pend != '0)
		else $error("beat accepted with nothing pending");
	a_pend_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (pend <= fill_n && fill_n <= DEPTH_C))
		else $error("pending count beyond ring fill");
endmodule

// ===== hw/rtl/gts_back.sv =====
// gts_back: ring write, gaussian tap walk, rounding divide and saturated result register
// depends on gts_pkg, gts_ram and gts_div
module gts_back #(
	parameter int RADIUS = 60
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_empty,
	input  gts_pkg::gts_cmd_t       cmd,
	output logic                    cmd_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic [15:0]             frame_index,
	output logic signed [31:0]      diff_x,
	output logic signed [31:0]      diff_y,
	output logic signed [23:0]      diff_angle,
	output logic                    last_result
);
	import gts_pkg::*;

	localparam int DEPTH = 2 * RADIUS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int WI    = $clog2(RADIUS + 1);
	localparam int OFF_W = CNT_W + 2;
	localparam int RW    = 3 * PATH_W;
	localparam longint unsigned Den4 = 4 * RADIUS * RADIUS;
	localparam longint unsigned One30 = 64'd1 << 30;
	localparam logic [CNT_W-1:0] RAD_C = CNT_W'(RADIUS);

	function automatic logic [WGT_W-1:0] wgt(input int J);
		longint unsigned u, mag, sm, w;
		u   = ((longint'(J) * longint'(J)) << 30) / Den4;
		mag = One30;
		sm  = One30;
		for (int K = 1; K <= 12; K++) begin
			mag = ((mag * u) >> 30) / K;
			if (K[0]) sm = sm - mag;
			else sm = sm + mag;
		end
		for (int r = 0; r < 3; r++) begin
			sm = (sm * sm + (One30 >> 1)) >> 30;
		end
		w = (sm + (64'd1 << 13)) >> 14;
		return (w > 64'd65535) ? 16'hFFFF : w[WGT_W-1:0];
	endfunction

	logic [WGT_W-1:0] wrom [RADIUS + 1];
	for (genvar g = 0; g <= RADIUS; g++) begin : g_rom
		localparam logic [WGT_W-1:0] W = wgt(g);
		assign wrom[g] = W;
	end

	bk_state_t state_q, state_n;

	logic [AW-1:0]    wp_q, newest_q, t_q, rd_addr;
	logic [CNT_W-1:0] fill_q, age_q, rem_q, rem_ld, age_ld;
	logic             eoc_q;
	logic [IDX_W-1:0] fidx_q;

	logic iss, div_start, out_load, walk_clr;

	logic signed [OFF_W-1:0] a_off;
	logic                    tap_ok, center;
	logic [AW:0]             s_tmp;
	logic [WI-1:0]           widx;
	logic [RW-1:0]           rdata;

	logic                     iss_s1, ok_s1, ctr_s1;
	logic [WGT_W-1:0]         w_s1;
	logic                     iss_s2, ok_s2;
	logic [WGT_W-1:0]         w_s2;
	logic signed [PROD_W-1:0] prx_s2, pry_s2, pra_s2;

	logic signed [ACC_W-1:0]  acx_q, acy_q, aca_q;
	logic [WSUM_W-1:0]        ws_q;
	logic signed [PATH_W-1:0] rx_q, ry_q, ra_q;
	logic                     nx_q, ny_q, na_q;

	logic [ACC_W-1:0] numx, numy, numa, qx, qy, qa;
	logic             bx, by, ba;
	logic signed [ACC_W-1:0] dfx, dfy, dfa;

	logic out_v_q;

	gts_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ring (
		.clk   (clk),
		.we    (cmd_pop),
		.waddr (wp_q),
		.wdata ({cmd.px, cmd.py, cmd.pa}),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// classify the popped frame
	always_comb begin
		rem_ld = '0;
		age_ld = '0;
		if (cmd.eoc) begin
			rem_ld = cmd.pend;
			age_ld = cmd.pend - 1'b1;
		end else if (cmd.pend > RAD_C) begin
			rem_ld = CNT_W'(1);
			age_ld = RAD_C;
		end
	end

	// tap address
	always_comb begin
		a_off  = $signed(OFF_W'(age_q)) + $signed(OFF_W'(RADIUS)) - $signed(OFF_W'(t_q));
		tap_ok = !a_off[OFF_W-1] && (a_off[CNT_W-1:0] < fill_q);
		s_tmp  = (AW + 1)'(newest_q) - (AW + 1)'(a_off[CNT_W-1:0]);
		if (!tap_ok) begin
			rd_addr = '0;
		end else if (s_tmp[AW]) begin
			rd_addr = AW'(s_tmp + (AW + 1)'(DEPTH));
		end else begin
			rd_addr = s_tmp[AW-1:0];
		end
		widx   = (t_q < AW'(RADIUS)) ? WI'(AW'(RADIUS) - t_q) : WI'(t_q - AW'(RADIUS));
		center = t_q == AW'(RADIUS);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					state_n = (rem_ld != '0) ? BK_WALK : BK_IDLE;
				end
			end
			BK_WALK: begin
				if (t_q == AW'(DEPTH - 1)) state_n = BK_DRAIN;
			end
			BK_DRAIN: begin
				if (!iss_s1 && !iss_s2) state_n = BK_DIV;
			end
			BK_DIV:  state_n = BK_WAIT;
			BK_WAIT: begin
				if (!bx) state_n = BK_OUT;
			end
			BK_OUT: begin
				if (!out_v_q || pop) begin
					state_n = (rem_q == CNT_W'(1)) ? BK_IDLE : BK_WALK;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		iss       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			BK_IDLE:  cmd_pop   = !cmd_empty;
			BK_WALK:  iss       = 1'b1;
			BK_DIV:   div_start = 1'b1;
			BK_OUT:   out_load  = !out_v_q || pop;
			default: begin
			end
		endcase
	end

	assign walk_clr = (cmd_pop && rem_ld != '0) || (out_load && rem_q != CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			wp_q     <= '0;
			newest_q <= '0;
			t_q      <= '0;
			fill_q   <= '0;
			age_q    <= '0;
			rem_q    <= '0;
			eoc_q    <= 1'b0;
			fidx_q   <= '0;
			iss_s1   <= 1'b0;
			iss_s2   <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			iss_s1  <= iss;
			iss_s2  <= iss_s1;
			if (cmd_pop) begin
				newest_q <= wp_q;
				wp_q     <= (cmd.eoc || wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
				fill_q   <= cmd.fill;
				eoc_q    <= cmd.eoc;
				fidx_q   <= cmd.fidx;
				rem_q    <= rem_ld;
				age_q    <= age_ld;
			end
			if (walk_clr) begin
				t_q <= '0;
			end else if (iss) begin
				t_q <= t_q + 1'b1;
			end
			if (out_load) begin
				rem_q   <= rem_q - 1'b1;
				age_q   <= age_q - 1'b1;
				fidx_q  <= fidx_q + 1'b1;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// tap pipeline: address, read and weight, product, accumulate
	always_ff @(posedge clk) begin
		ok_s1  <= tap_ok;
		ctr_s1 <= center;
		w_s1   <= wrom[widx];
		ok_s2  <= ok_s1;
		w_s2   <= w_s1;
		prx_s2 <= $signed(rdata[3*PATH_W-1:2*PATH_W]) * $signed({1'b0, w_s1});
		pry_s2 <= $signed(rdata[2*PATH_W-1:PATH_W]) * $signed({1'b0, w_s1});
		pra_s2 <= $signed(rdata[PATH_W-1:0]) * $signed({1'b0, w_s1});
		if (iss_s1 && ctr_s1) begin
			rx_q <= rdata[3*PATH_W-1:2*PATH_W];
			ry_q <= rdata[2*PATH_W-1:PATH_W];
			ra_q <= rdata[PATH_W-1:0];
		end
		if (walk_clr) begin
			acx_q <= '0;
			acy_q <= '0;
			aca_q <= '0;
			ws_q  <= '0;
		end else if (iss_s2 && ok_s2) begin
			acx_q <= acx_q + ACC_W'(prx_s2);
			acy_q <= acy_q + ACC_W'(pry_s2);
			aca_q <= aca_q + ACC_W'(pra_s2);
			ws_q  <= ws_q + WSUM_W'(w_s2);
		end
		if (div_start) begin
			nx_q <= acx_q[ACC_W-1];
			ny_q <= acy_q[ACC_W-1];
			na_q <= aca_q[ACC_W-1];
		end
	end

	// magnitude plus half the weight sum gives round half away from zero
	assign numx = (acx_q[ACC_W-1] ? ~acx_q : acx_q) + ACC_W'(acx_q[ACC_W-1])
		+ ACC_W'(ws_q >> 1);
	assign numy = (acy_q[ACC_W-1] ? ~acy_q : acy_q) + ACC_W'(acy_q[ACC_W-1])
		+ ACC_W'(ws_q >> 1);
	assign numa = (aca_q[ACC_W-1] ? ~aca_q : aca_q) + ACC_W'(aca_q[ACC_W-1])
		+ ACC_W'(ws_q >> 1);

	gts_div #(.NUM_W(ACC_W), .DEN_W(WSUM_W)) u_divx (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(numx), .den(ws_q),
		.busy(bx), .quot(qx)
	);
	gts_div #(.NUM_W(ACC_W), .DEN_W(WSUM_W)) u_divy (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(numy), .den(ws_q),
		.busy(by), .quot(qy)
	);
	gts_div #(.NUM_W(ACC_W), .DEN_W(WSUM_W)) u_diva (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(numa), .den(ws_q),
		.busy(ba), .quot(qa)
	);

	assign dfx = $signed(nx_q ? ~qx : qx) - ACC_W'(rx_q) + ACC_W'(nx_q);
	assign dfy = $signed(ny_q ? ~qy : qy) - ACC_W'(ry_q) + ACC_W'(ny_q);
	assign dfa = $signed(na_q ? ~qa : qa) - ACC_W'(ra_q) + ACC_W'(na_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			frame_index <= fidx_q;
			diff_x      <= sat32(dfx);
			diff_y      <= sat32(dfy);
			diff_angle  <= sat24(dfa);
			last_result <= eoc_q && rem_q == CNT_W'(1);
		end
	end

	assign empty = !out_v_q;

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		iss |-> (AW + 1)'(rd_addr) < (AW + 1)'(DEPTH))
		else $error("ring address out of range");
	a_wsum: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (ws_q != '0 && !iss_s1 && !iss_s2))
		else $error("divide started with empty weight sum or busy pipeline");
	a_div_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(bx == by) && (by == ba))
		else $error("dividers out of step");
	a_load_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> rem_q != '0)
		else $error("result beat with no correction pending");
endmodule
